// File: sv/sli_pkg.sv
// Shared constants and types for the sorted list block.
`timescale 1ns / 1ps
package sli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SRCH = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Control from the sequencer to the row of cells
    typedef struct packed {
        logic cmp_en;
        logic ins;
        logic del;
    } t_chain_ctl;

endpackage

// File: sv/sli_cell.sv
// One cell of the list: holds a value, compares it with the key, shifts with its neighbours.
`timescale 1ns / 1ps
module sli_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                                  i_clk,
    input  sli_pkg::t_chain_ctl                   i_ctl,
    input  logic signed [sli_pkg::VALUE_W-1:0]    i_key,
    input  logic [CW-1:0]                         i_pos,
    input  logic signed [sli_pkg::VALUE_W-1:0]    i_left,
    input  logic signed [sli_pkg::VALUE_W-1:0]    i_right,
    output logic signed [sli_pkg::VALUE_W-1:0]    o_entry,
    output logic                                  o_lt,
    output logic                                  o_eq
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic signed [sli_pkg::VALUE_W-1:0] r_entry;
    logic                               r_lt;
    logic                               r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= (r_entry < i_key);
            r_eq <= (r_entry == i_key);
        end
    end

    // Insert: cells above the slot take the left neighbour, the slot takes the key.
    // Delete: the slot and everything above take the right neighbour.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                r_entry <= i_left;
            end else if (MY_IDX == i_pos) begin
                r_entry <= i_key;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                r_entry <= i_right;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// File: sv/sli_chain.sv
// Row of list cells, each linked to its lower and upper neighbour.
`timescale 1ns / 1ps
module sli_chain #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                               i_clk,
    input  sli_pkg::t_chain_ctl                i_ctl,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_key,
    input  logic [CW-1:0]                      i_pos,
    output logic [CAPACITY-1:0]                o_lt,
    output logic [CAPACITY-1:0]                o_eq
);

    logic signed [sli_pkg::VALUE_W-1:0] w_entry [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [sli_pkg::VALUE_W-1:0] w_left;
        logic signed [sli_pkg::VALUE_W-1:0] w_right;

        // Ends: cell 0 never takes its left; the last cell's right is itself, harmless
        if (g == 0) begin : g_first
            assign w_left = i_key;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        sli_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_key   (i_key),
            .i_pos   (i_pos),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_lt    (o_lt[g]),
            .o_eq    (o_eq[g])
        );
    end

endmodule

// File: sv/sli_search.sv
// Binary search over the registered compare flags, one probe per cycle.
`timescale 1ns / 1ps
module sli_search #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_start,
    input  logic                i_step,
    input  logic                i_del,
    input  logic [CW-1:0]       i_count,
    input  logic [CAPACITY-1:0] i_lt,
    input  logic [CAPACITY-1:0] i_eq,
    output logic                o_done,
    output logic [CW-1:0]       o_pos
);

    localparam int IW = $clog2(CAPACITY);

    // Window is [r_lo, r_hp): r_hp is one past the upper bound
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hp;
    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic [IW-1:0] w_idx;
    logic          w_empty;

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hp} - (CW+1)'(1);
    assign w_mid   = w_sum[CW:1];
    assign w_idx   = w_mid[IW-1:0];
    assign w_empty = (r_lo >= r_hp);

    // An insert stops on the first equal probe; a delete runs to the lower bound
    assign o_done = w_empty ? 1'b1 : (!i_del && i_eq[w_idx]);
    assign o_pos  = w_empty ? r_lo : w_mid;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo <= '0;
            r_hp <= i_count;
        end else if (i_step && !o_done) begin
            if (i_lt[w_idx]) begin
                r_lo <= w_mid + CW'(1);
            end else begin
                r_hp <= w_mid;
            end
        end
    end

endmodule

// File: sv/sorted_list_insert_delete.sv
// Sorted list of signed values with insert and delete requests.
//
// Holds up to CAPACITY signed 32-bit values in ascending order in a row of
// cells. An insert (req_type 0) places the value at the point found by a
// binary search and moves larger entries up; a full list rejects it. A
// delete (req_type 1) removes the first entry equal to the value, or
// reports not found. One request is handled at a time: after the transfer,
// every cell compares its value with the key in the compare state, then the
// binary search steps one probe per cycle over those compare flags (the
// shift of the cells happening when the search finishes), and the result is
// then held until it is taken. No new request is taken until the result has
// been taken. Entries need no clearing after reset, since only entries below
// the count are ever used.
`timescale 1ns / 1ps
module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sli_pkg::STATUS_W-1:0]       o_status,
    output logic [sli_pkg::POS_W-1:0]          o_position,
    output logic [sli_pkg::POS_W-1:0]          o_count,
    output logic                               o_is_full,
    output logic                               o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sli_pkg::t_state r_state;
    sli_pkg::t_state n_state;

    logic signed [sli_pkg::VALUE_W-1:0] r_key;
    logic                               r_del;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic [CW-1:0]                      r_pos;
    logic [sli_pkg::STATUS_W-1:0]       r_status;
    logic [sli_pkg::STATUS_W-1:0]       n_status;

    sli_pkg::t_chain_ctl  w_ctl;
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;
    logic                 w_done;
    logic [CW-1:0]        w_pos;
    logic                 w_finish;
    logic                 w_found;
    logic [31:0]          w_pos_ext;
    logic [31:0]          w_cnt_ext;

    assign w_finish = (r_state == sli_pkg::S_SRCH) && w_done;
    assign w_found  = (w_pos < r_count) ? w_eq[w_pos[IW-1:0]] : 1'b0;

    always_comb begin
        n_status = r_status;
        n_count  = r_count;
        w_ctl    = '0;
        w_ctl.cmp_en = (r_state == sli_pkg::S_CMP);
        if (r_del) begin
            if (w_found) begin
                n_status  = sli_pkg::ST_DELETED;
                n_count   = r_count - CW'(1);
                w_ctl.del = w_finish;
            end else begin
                n_status = sli_pkg::ST_NOT_FOUND;
            end
        end else begin
            if (r_count >= CAP_C) begin
                n_status = sli_pkg::ST_FULL;
            end else begin
                n_status  = sli_pkg::ST_INSERTED;
                n_count   = r_count + CW'(1);
                w_ctl.ins = w_finish;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sli_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = sli_pkg::S_CMP;
                end
            end
            sli_pkg::S_CMP: begin
                n_state = sli_pkg::S_SRCH;
            end
            sli_pkg::S_SRCH: begin
                if (w_done) begin
                    n_state = sli_pkg::S_OUT;
                end
            end
            sli_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = sli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sli_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_count <= n_count;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        if (r_state == sli_pkg::S_IDLE && i_valid) begin
            r_key <= i_value;
            r_del <= i_req_type;
        end
        if (w_finish) begin
            r_pos    <= w_pos;
            r_status <= n_status;
        end
    end

    sli_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_key (r_key),
        .i_pos (w_pos),
        .o_lt  (w_lt),
        .o_eq  (w_eq)
    );

    sli_search #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_search (
        .i_clk   (i_clk),
        .i_start (r_state == sli_pkg::S_CMP),
        .i_step  (r_state == sli_pkg::S_SRCH),
        .i_del   (r_del),
        .i_count (r_count),
        .i_lt    (w_lt),
        .i_eq    (w_eq),
        .o_done  (w_done),
        .o_pos   (w_pos)
    );

    assign w_pos_ext = 32'(r_pos);
    assign w_cnt_ext = 32'(r_count);

    assign o_ready    = (r_state == sli_pkg::S_IDLE);
    assign o_valid    = (r_state == sli_pkg::S_OUT);
    assign o_status   = r_status;
    assign o_position = w_pos_ext[sli_pkg::POS_W-1:0];
    assign o_count    = w_cnt_ext[sli_pkg::POS_W-1:0];
    assign o_is_full  = (r_count == CAP_C);
    assign o_is_empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_count_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_finish |=> $stable(r_count))
        else $error("entry count moved outside a search finish");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && o_status == sli_pkg::ST_INSERTED
            |-> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list by one");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && o_status == sli_pkg::ST_DELETED
            |-> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink the list by one");

    a_position_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sli_pkg::ST_DELETED || o_status == sli_pkg::ST_INSERTED)
            |-> r_pos < CAP_C)
        else $error("result position outside the list");

endmodule
